[rtl/sem_pkg.sv]
package sem_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_req_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       last_in_frame;
  } out_rsp_t;

  // per-request control decided by the front end
  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    item_ctl_t   ctl;
    logic [23:0] rgb;  // blue, green, red from msb down
  } item_t;

  typedef struct packed {
    logic [7:0] root;
    logic [8:0] rem;
  } sqrt_st_t;

  localparam logic CMD_DRAIN = 1'b1;

  localparam logic REG_SEL_WIDTH  = 1'b0;
  localparam logic REG_SEL_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // one digit of the restoring square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
    logic [10:0] r;
    logic [10:0] trial;
    sqrt_st_t    n;
    r     = {s.rem, pair};
    trial = {1'b0, s.root, 2'b01};
    if (r >= trial) begin
      n.rem  = 9'(r - trial);
      n.root = {s.root[6:0], 1'b1};
    end else begin
      n.rem  = r[8:0];
      n.root = {s.root[6:0], 1'b0};
    end
    return n;
  endfunction

endpackage

[rtl/sem_front.sv]
module sem_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int COL_W      = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic [10:0]           cfg_width_i,
  input  logic [12:0]           cfg_height_i,
  input  logic                  in_valid_i,
  input  sem_pkg::in_req_t      in_req_i,
  output logic                  in_stall_o,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output sem_pkg::item_t        q_item_o,
  output logic [COL_W-1:0]      q_col_o
);
  import sem_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [HW-1:0]    in_row_q, out_row_q;
  logic [COL_W:0]   in_col_nxt, out_col_nxt;
  logic             draining, accept, emit, last_item;

  always_comb begin
    if (cfg_width_i == '0) begin
      w = WW'(1);
    end else if (int'(cfg_width_i) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      h = HW'(1);
    end else if (int'(cfg_height_i) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg_height_i);
    end
  end

  assign in_col_nxt  = (COL_W+1)'(in_col_q) + 1'b1;
  assign out_col_nxt = (COL_W+1)'(out_col_q) + 1'b1;
  assign draining    = in_row_q >= h;
  assign emit        = (in_row_q > HW'(1)) || (in_row_q == HW'(1) && in_col_q != '0);
  assign last_item   = (in_row_q == h + HW'(1)) && (in_col_q == '0);

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // a drain ahead of the frame end is dropped here
  assign q_push_o   = accept && (draining || in_req_i.command != CMD_DRAIN);
  assign q_col_o    = in_col_q;

  always_comb begin
    q_item_o.rgb = draining ? 24'd0
                 : {in_req_i.pixel_blue, in_req_i.pixel_green, in_req_i.pixel_red};
    q_item_o.ctl.emit     = emit;
    q_item_o.ctl.top_ok   = out_row_q != '0;
    q_item_o.ctl.bot_ok   = (out_row_q + HW'(1)) < h;
    q_item_o.ctl.left_ok  = out_col_q != '0;
    q_item_o.ctl.right_ok = out_col_nxt < (COL_W+1)'(w);
    q_item_o.ctl.last     = (out_row_q + HW'(1) == h) && (out_col_nxt == (COL_W+1)'(w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (restart_i || (q_push_o && last_item)) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (q_push_o) begin
      if (in_col_nxt >= (COL_W+1)'(w)) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + HW'(1);
      end else begin
        in_col_q <= in_col_nxt[COL_W-1:0];
      end
      if (emit) begin
        if (out_col_nxt >= (COL_W+1)'(w)) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HW'(1);
        end else begin
          out_col_q <= out_col_nxt[COL_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/sem_queue.sv]
module sem_queue #(
  parameter int COL_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sem_pkg::item_t   push_item_i,
  input  logic [COL_W-1:0] push_col_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sem_pkg::item_t   pop_item_o,
  output logic [COL_W-1:0] pop_col_o
);
  import sem_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  item_t            items_q [DEPTH];
  logic [COL_W-1:0] cols_q  [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o     = count_q == (PW+1)'(DEPTH);
  assign valid_o    = count_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = items_q[rd_ptr_q];
  assign pop_col_o  = cols_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      items_q[wr_ptr_q] <= push_item_i;
      cols_q[wr_ptr_q]  <= push_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

[rtl/sem_back.sv]
module sem_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sem_pkg::item_t     q_item_i,
  input  logic [COL_W-1:0]   q_col_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sem_pkg::out_rsp_t  out_rsp_o
);
  import sem_pkg::*;

  localparam logic [20:0] SAT_LIMIT = 21'd65280;

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] lower_mem [MAX_WIDTH];

  logic        en;
  // read stage
  logic             a_valid_q;
  item_t            a_item_q;
  logic [COL_W-1:0] a_col_q;
  logic [23:0]      top_raw_q, mid_raw_q, byp_top_q, byp_mid_q;
  logic             byp_q;
  logic [23:0]      top_eff, mid_eff;
  // window stage
  logic [23:0]      win_q [3][3];
  logic             w_valid_q;
  item_ctl_t        w_ctl_q;
  // gradient stage
  logic               g_valid_q, g_last_q;
  logic signed [10:0] gx_q [3];
  logic signed [10:0] gy_q [3];
  logic signed [10:0] gx_d [3];
  logic signed [10:0] gy_d [3];
  logic [2:0]         rowok, colok;
  logic [7:0]         v [3][3][3];
  logic [9:0]         sl [3];
  logic [9:0]         sr [3];
  logic [9:0]         st [3];
  logic [9:0]         sb [3];
  // square stage
  logic               s_valid_q, s_last_q;
  logic [15:0]        s_x_q [3];
  logic [2:0]         s_sat_q;
  logic signed [21:0] px2 [3];
  logic signed [21:0] py2 [3];
  logic [20:0]        sum [3];
  // upper root digits
  logic               h_valid_q, h_last_q;
  sqrt_st_t           h_st_q [3];
  sqrt_st_t           h_st_d [3];
  logic [7:0]         h_lo_q [3];
  logic [2:0]         h_sat_q;
  // lower root digits and rounding
  sqrt_st_t           f_st [3];
  logic [7:0]         m [3];
  logic               out_valid_q;
  out_rsp_t           out_rsp_q;

  // the whole back end advances together unless a result is held
  assign en          = !(out_valid_q && out_stall_i);
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // same column read right after its write (width of one)
  assign top_eff = byp_q ? byp_top_q : top_raw_q;
  assign mid_eff = byp_q ? byp_mid_q : mid_raw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      top_raw_q <= upper_mem[q_col_i];
      mid_raw_q <= lower_mem[q_col_i];
      if (a_valid_q) begin
        upper_mem[a_col_q] <= mid_eff;
        lower_mem[a_col_q] <= a_item_q.rgb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q  <= q_item_i;
      a_col_q   <= q_col_i;
      byp_top_q <= mid_eff;
      byp_mid_q <= a_item_q.rgb;
      w_ctl_q   <= a_item_q.ctl;
      if (a_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= top_eff;
        win_q[1][2] <= mid_eff;
        win_q[2][2] <= a_item_q.rgb;
      end
      g_last_q <= w_ctl_q.last;
      s_last_q <= g_last_q;
      h_last_q <= s_last_q;
      for (int ch = 0; ch < 3; ch++) begin
        gx_q[ch]    <= gx_d[ch];
        gy_q[ch]    <= gy_d[ch];
        s_x_q[ch]   <= sum[ch][15:0];
        s_sat_q[ch] <= sum[ch] > SAT_LIMIT;
        h_st_q[ch]  <= h_st_d[ch];
        h_lo_q[ch]  <= s_x_q[ch][7:0];
        h_sat_q[ch] <= s_sat_q[ch];
      end
    end
  end

  // gradients on the masked window
  always_comb begin
    rowok = {w_ctl_q.bot_ok, 1'b1, w_ctl_q.top_ok};
    colok = {w_ctl_q.right_ok, 1'b1, w_ctl_q.left_ok};
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v[ch][r][c] = (rowok[r] && colok[c]) ? win_q[r][c][8*ch +: 8] : 8'd0;
        end
      end
      sl[ch] = 10'(v[ch][0][0]) + (10'(v[ch][1][0]) << 1) + 10'(v[ch][2][0]);
      sr[ch] = 10'(v[ch][0][2]) + (10'(v[ch][1][2]) << 1) + 10'(v[ch][2][2]);
      st[ch] = 10'(v[ch][0][0]) + (10'(v[ch][0][1]) << 1) + 10'(v[ch][0][2]);
      sb[ch] = 10'(v[ch][2][0]) + (10'(v[ch][2][1]) << 1) + 10'(v[ch][2][2]);
      gx_d[ch] = $signed({1'b0, sr[ch]}) - $signed({1'b0, sl[ch]});
      gy_d[ch] = $signed({1'b0, sb[ch]}) - $signed({1'b0, st[ch]});
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      px2[ch] = gx_q[ch] * gx_q[ch];
      py2[ch] = gy_q[ch] * gy_q[ch];
      sum[ch] = 21'(px2[ch][19:0]) + 21'(py2[ch][19:0]);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      h_st_d[ch] = '0;
      for (int i = 0; i < 4; i++) begin
        h_st_d[ch] = sqrt_step(h_st_d[ch], s_x_q[ch][15-2*i -: 2]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      f_st[ch] = h_st_q[ch];
      for (int i = 0; i < 4; i++) begin
        f_st[ch] = sqrt_step(f_st[ch], h_lo_q[ch][7-2*i -: 2]);
      end
      // round up when the remainder passes the root
      if (h_sat_q[ch]) begin
        m[ch] = 8'd255;
      end else if (f_st[ch].rem > {1'b0, f_st[ch].root}) begin
        m[ch] = f_st[ch].root + 8'd1;
      end else begin
        m[ch] = f_st[ch].root;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && h_valid_q) begin
      out_rsp_q.edge_red      <= m[0];
      out_rsp_q.edge_green    <= m[1];
      out_rsp_q.edge_blue     <= m[2];
      out_rsp_q.last_in_frame <= h_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      byp_q       <= 1'b0;
      w_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= q_valid_i;
      byp_q       <= a_valid_q && (a_col_q == q_col_i);
      w_valid_q   <= a_valid_q && a_item_q.ctl.emit;
      g_valid_q   <= w_valid_q;
      s_valid_q   <= g_valid_q;
      h_valid_q   <= s_valid_q;
      out_valid_q <= h_valid_q;
    end
  end

endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
// channel   direction  handshake             payload
// in        request    in_valid_i/in_stall_o in_req_i (command, pixel rgb)
// out       result     out_valid_o/out_stall_i out_rsp_o (edge rgb, last_in_frame)
// cfg       apb access psel/penable/pready   paddr, pwdata, prdata
//
// one request per clock while in_stall_o is low, set by the line stores being read and written in the same cycle;
// out_valid_o rises once the releasing request has left the 4-entry queue and passed the read,
// window, gradient, square, upper-root and output registers.
// reset clears counters, queue and pipeline valids; line stores are not cleared.
// a held result freezes the whole back end; the queue absorbs up to 4 requests
// before in_stall_o rises.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sem_pkg::in_req_t  in_req_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sem_pkg::out_rsp_t out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [10:0]      width_q;
  logic [12:0]      height_q;
  logic             cfg_wr;
  logic             push, full, q_valid, pop;
  item_t            push_item, pop_item;
  logic [COL_W-1:0] push_col, pop_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_SEL_WIDTH:  prdata = {21'd0, width_q};
      REG_SEL_HEIGHT: prdata = {19'd0, height_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEL_WIDTH) begin
        width_q <= pwdata[10:0];
      end else begin
        height_q <= pwdata[12:0];
      end
    end
  end

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_W     (COL_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_wr),
    .cfg_width_i (width_q),
    .cfg_height_i(height_q),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_item_o    (push_item),
    .q_col_o     (push_col)
  );

  sem_queue #(
    .COL_W(COL_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .push_col_i (push_col),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_item_o (pop_item),
    .pop_col_o  (pop_col)
  );

  sem_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (pop_item),
    .q_col_i    (pop_col),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

[rtl/sem_checker.sv]
module sem_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sem_pkg::out_rsp_t out_rsp_o,
  input logic              psel,
  input logic              penable,
  input logic              pready
);
  import sem_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // the queue is empty under reset, so requests are never refused then
  a_reset_no_stall: assert property (@(posedge clk_i)
    !rst_ni |-> !in_stall_o)
    else $error("stall asserted during reset");

  // the access phase always sees pready high, so no wait states are inserted
  a_apb_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("access cycle not ready");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
